// ===== rtl/bayer_bilinear_demosaic_core_defines.svh =====
// Assertion macros shared by the demosaic core RTL.
// Needs clk and rst_n in scope at the point of use.
`ifndef BAYER_BILINEAR_DEMOSAIC_CORE_DEFINES_SVH
`define BAYER_BILINEAR_DEMOSAIC_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define BBD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define BBD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bbd_pkg.sv =====
// Shared types and codes for the bilinear Bayer demosaic core.
// No dependencies.
package bbd_pkg;

  localparam logic KIND_PIXEL       = 1'b0;

  localparam int   CFG_AW           = 1;
  localparam int   CFG_DW           = 13;
  localparam logic CFG_FRAME_WIDTH  = 1'b0;
  localparam logic CFG_FRAME_HEIGHT = 1'b1;

  localparam int   ROW_W            = 12;
  localparam int   COL_W            = 11;

  localparam int   QUEUE_DEPTH      = 4;
  localparam int   QPTR_W           = 2;

  // Site colour from {row parity, column parity}, GBRG mosaic
  typedef enum logic [1:0] {
    SITE_GB = 2'b00,
    SITE_B  = 2'b01,
    SITE_R  = 2'b10,
    SITE_GR = 2'b11
  } site_t;

  typedef struct packed {
    logic [7:0] top;
    logic [7:0] mid;
    logic [7:0] bot;
  } pix_col_t;

  typedef struct packed {
    logic  row_first;
    logic  row_last;
    logic  col_first;
    logic  col_last;
    site_t site;
  } border_t;

  typedef struct packed {
    pix_col_t         px;
    logic             emit;
    logic             last;
    border_t          border;
    logic [ROW_W-1:0] row_idx;
    logic [COL_W-1:0] col_idx;
  } q_entry_t;

endpackage

// ===== rtl/bbd_front.sv =====
// Front end: frame registers, raster counters, two-row line store and classification.
// Depends on bbd_pkg and bayer_bilinear_demosaic_core_defines.svh.
`include "bayer_bilinear_demosaic_core_defines.svh"

module bbd_front import bbd_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_kind,
  input  logic [7:0]        in_pixel_value,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata,
  output logic              push,
  output q_entry_t          push_entry,
  input  logic              q_full
);

  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT + 2);
  localparam int OW    = $clog2(MAX_HEIGHT);
  localparam int W_CAP = (MAX_WIDTH / 2) * 2;
  localparam int H_CAP = (MAX_HEIGHT / 2) * 2;
  localparam logic [12:0] W_LIM = (W_CAP > 4094) ? 13'd4094 : 13'(W_CAP);
  localparam logic [12:0] H_LIM = (H_CAP > 8190) ? 13'd8190 : 13'(H_CAP);

  function automatic logic [12:0] eff_dim(input logic [12:0] v, input logic [12:0] lim);
    logic [12:0] e;
    e = {v[12:1], 1'b0};
    if (e < 13'd2) e = 13'd2;
    if (e > lim) e = lim;
    return e;
  endfunction

  logic [11:0]   eff_w_r;
  logic [12:0]   eff_h_r;
  logic [RW-1:0] in_row_r, in_row_nxt;
  logic [AW-1:0] in_col_r, in_col_nxt;
  logic [OW-1:0] out_row_r, out_row_nxt;
  logic [AW-1:0] out_col_r, out_col_nxt;
  logic [15:0]   rd_r;
  logic [15:0]   line_mem [MAX_WIDTH];

  logic in_fire, full, started, adv, mem_we, emit, last;
  logic col_end, ocol_end, orow_end;

  assign in_stall = q_full;
  assign in_fire  = in_valid && !in_stall;

  assign full     = 16'(in_row_r) >= 16'(eff_h_r);
  assign started  = (16'(in_row_r) >= 16'd2) || ((16'(in_row_r) == 16'd1) && (in_col_r != '0));
  assign col_end  = 16'(in_col_r)  == (16'(eff_w_r) - 16'd1);
  assign ocol_end = 16'(out_col_r) == (16'(eff_w_r) - 16'd1);
  assign orow_end = 16'(out_row_r) == (16'(eff_h_r) - 16'd1);

  // drain ticks before frame end are swallowed; raw pixels after it act as drains
  assign adv    = in_fire && (full || (in_kind == KIND_PIXEL));
  assign mem_we = in_fire && (in_kind == KIND_PIXEL) && !full;
  assign emit   = adv && started;
  assign last   = orow_end && ocol_end;

  always_comb begin
    in_row_nxt  = in_row_r;
    in_col_nxt  = in_col_r;
    out_row_nxt = out_row_r;
    out_col_nxt = out_col_r;
    if (cfg_we || (emit && last)) begin
      in_row_nxt  = '0;
      in_col_nxt  = '0;
      out_row_nxt = '0;
      out_col_nxt = '0;
    end else if (adv) begin
      if (col_end) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + RW'(1);
      end else begin
        in_col_nxt = in_col_r + AW'(1);
      end
      if (emit) begin
        if (ocol_end) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + OW'(1);
        end else begin
          out_col_nxt = out_col_r + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_w_r   <= 12'(eff_dim(13'd640, W_LIM));
      eff_h_r   <= eff_dim(13'd480, H_LIM);
      in_row_r  <= '0;
      in_col_r  <= '0;
      out_row_r <= '0;
      out_col_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_FRAME_WIDTH:  eff_w_r <= 12'(eff_dim({1'b0, cfg_wdata[11:0]}, W_LIM));
          CFG_FRAME_HEIGHT: eff_h_r <= eff_dim(cfg_wdata, H_LIM);
        endcase
      end
      in_row_r  <= in_row_nxt;
      in_col_r  <= in_col_nxt;
      out_row_r <= out_row_nxt;
      out_col_r <= out_col_nxt;
    end
  end

  // each entry holds {two rows up, one row up}; read runs one column ahead
  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[in_col_r] <= {rd_r[7:0], in_pixel_value};
    end
    rd_r <= line_mem[in_col_nxt];
  end

  assign push = adv;

  always_comb begin
    push_entry.px.top           = rd_r[15:8];
    push_entry.px.mid           = rd_r[7:0];
    push_entry.px.bot           = in_pixel_value;
    push_entry.emit             = emit;
    push_entry.last             = last;
    push_entry.border.row_first = (out_row_r == '0);
    push_entry.border.row_last  = orow_end;
    push_entry.border.col_first = (out_col_r == '0);
    push_entry.border.col_last  = ocol_end;
    push_entry.border.site      = site_t'({out_row_r[0], out_col_r[0]});
    push_entry.row_idx          = ROW_W'(out_row_r);
    push_entry.col_idx          = COL_W'(out_col_r);
  end

  `BBD_ASSERT_NXT(a_last_restarts, emit && last, {in_row_r, in_col_r, out_col_r} == '0, "no restart")
  `BBD_ASSERT_IMP(a_row_bound, adv, 16'(in_row_r) <= 16'(eff_h_r) + 16'd1, "row overrun")

endmodule

// ===== rtl/bbd_queue.sv =====
// Short transaction queue between the front end and the interpolation back end.
// Depends on bbd_pkg and bayer_bilinear_demosaic_core_defines.svh.
`include "bayer_bilinear_demosaic_core_defines.svh"

module bbd_queue import bbd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_entry,
  output logic     full,
  input  logic     pop,
  output logic     not_empty,
  output q_entry_t head
);

  q_entry_t          slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r;

  assign full      = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      count_r <= count_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

  `BBD_ASSERT_IMP(a_no_underflow, pop, count_r != '0, "pop from empty queue")

endmodule

// ===== rtl/bbd_back.sv =====
// Back end: 3x3 window, bilinear interpolation and output register.
// Depends on bbd_pkg and bayer_bilinear_demosaic_core_defines.svh.
`include "bayer_bilinear_demosaic_core_defines.svh"

module bbd_back import bbd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             not_empty,
  input  q_entry_t         head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue,
  output logic [ROW_W-1:0] out_row,
  output logic [COL_W-1:0] out_col,
  output logic             out_last_of_frame
);

  typedef enum logic [1:0] {DIV1, DIV2, DIV3, DIV4} div_t;

  function automatic logic [9:0] sum4(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c, input logic [7:0] d);
    return 10'(a) + 10'(b) + 10'(c) + 10'(d);
  endfunction

  // /3 as multiply by 683/2048, exact for sums up to 765
  function automatic logic [7:0] avg(input logic [9:0] s, input div_t d);
    logic [18:0] p;
    logic [7:0]  q;
    p = 19'(s) * 19'd683;
    unique case (d)
      DIV1: q = s[7:0];
      DIV2: q = s[8:1];
      DIV3: q = p[18:11];
      DIV4: q = s[9:2];
    endcase
    return q;
  endfunction

  localparam logic [7:0] Z = 8'd0;

  pix_col_t win_l_r, win_c_r;
  logic     out_valid_r;
  logic [7:0] red_r, green_r, blue_r;
  logic [ROW_W-1:0] row_r;
  logic [COL_W-1:0] col_r;
  logic     last_r;

  logic [7:0] px_nw, px_n, px_ne, px_w, px_c, px_e, px_sw, px_s, px_se;
  logic [9:0] r_sum, g_sum, b_sum;
  div_t       r_div, g_div, b_div;
  border_t    bd;

  assign pop = not_empty && (!head.emit || !out_valid_r || !out_stall);

  assign px_nw = win_l_r.top;
  assign px_w  = win_l_r.mid;
  assign px_sw = win_l_r.bot;
  assign px_n  = win_c_r.top;
  assign px_c  = win_c_r.mid;
  assign px_s  = win_c_r.bot;
  assign px_ne = head.px.top;
  assign px_e  = head.px.mid;
  assign px_se = head.px.bot;
  assign bd    = head.border;

  always_comb begin
    r_sum = sum4(px_c, Z, Z, Z);
    g_sum = sum4(px_c, Z, Z, Z);
    b_sum = sum4(px_c, Z, Z, Z);
    r_div = DIV1;
    g_div = DIV1;
    b_div = DIV1;
    unique case (bd.site)
      SITE_GB: begin
        if (bd.col_first) begin
          b_sum = sum4(px_e, Z, Z, Z);
        end else begin
          b_sum = sum4(px_e, px_w, Z, Z);
          b_div = DIV2;
        end
        if (bd.row_first) begin
          r_sum = sum4(px_s, Z, Z, Z);
        end else begin
          r_sum = sum4(px_s, px_n, Z, Z);
          r_div = DIV2;
        end
      end
      SITE_GR: begin
        if (bd.row_last) begin
          b_sum = sum4(px_n, Z, Z, Z);
        end else begin
          b_sum = sum4(px_n, px_s, Z, Z);
          b_div = DIV2;
        end
        if (bd.col_last) begin
          r_sum = sum4(px_w, Z, Z, Z);
        end else begin
          r_sum = sum4(px_w, px_e, Z, Z);
          r_div = DIV2;
        end
      end
      SITE_B: begin
        if (bd.row_first && bd.col_last) begin
          r_sum = sum4(px_sw, Z, Z, Z);
          g_sum = sum4(px_s, px_w, Z, Z);
          g_div = DIV2;
        end else if (bd.row_first) begin
          r_sum = sum4(px_sw, px_se, Z, Z);
          r_div = DIV2;
          g_sum = sum4(px_s, px_e, px_w, Z);
          g_div = DIV3;
        end else if (bd.col_last) begin
          r_sum = sum4(px_nw, px_sw, Z, Z);
          r_div = DIV2;
          g_sum = sum4(px_s, px_n, px_w, Z);
          g_div = DIV3;
        end else begin
          r_sum = sum4(px_nw, px_ne, px_sw, px_se);
          r_div = DIV4;
          g_sum = sum4(px_s, px_n, px_w, px_e);
          g_div = DIV4;
        end
      end
      SITE_R: begin
        if (bd.row_last && bd.col_first) begin
          g_sum = sum4(px_e, px_n, Z, Z);
          g_div = DIV2;
          b_sum = sum4(px_ne, Z, Z, Z);
        end else if (bd.col_first) begin
          g_sum = sum4(px_e, px_n, px_s, Z);
          g_div = DIV3;
          b_sum = sum4(px_ne, px_se, Z, Z);
          b_div = DIV2;
        end else if (bd.row_last) begin
          g_sum = sum4(px_e, px_w, px_n, Z);
          g_div = DIV3;
          b_sum = sum4(px_ne, px_nw, Z, Z);
          b_div = DIV2;
        end else begin
          g_sum = sum4(px_e, px_w, px_n, px_s);
          g_div = DIV4;
          b_sum = sum4(px_ne, px_nw, px_se, px_sw);
          b_div = DIV4;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      win_l_r     <= '0;
      win_c_r     <= '0;
    end else begin
      if (pop) begin
        win_l_r <= win_c_r;
        win_c_r <= head.px;
      end
      if (pop && head.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.emit) begin
      red_r   <= avg(r_sum, r_div);
      green_r <= avg(g_sum, g_div);
      blue_r  <= avg(b_sum, b_div);
      row_r   <= head.row_idx;
      col_r   <= head.col_idx;
      last_r  <= head.last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_red           = red_r;
  assign out_green         = green_r;
  assign out_blue          = blue_r;
  assign out_row           = row_r;
  assign out_col           = col_r;
  assign out_last_of_frame = last_r;

  `BBD_ASSERT_NXT(a_emit_loads_out, pop && head.emit, out_valid_r, "emitted transaction lost")

endmodule

// ===== rtl/bayer_bilinear_demosaic_core.sv =====
// Top level of the GBRG bilinear demosaic core: front end, queue and back end.
// Depends on bbd_pkg, bbd_front, bbd_queue and bbd_back.
//
//   channel | handshake           | payload
//   --------+---------------------+--------------------------------------------------
//   in      | in_valid / in_stall | in_kind, in_pixel_value
//   out     | out_valid/out_stall | out_red/green/blue, out_row, out_col, out_last_of_frame
//   cfg     | cfg_we              | cfg_addr, cfg_wdata
//
// One transaction per clock while in_stall is low; the line store has one read and one
// write port, the read running one column ahead of the write.
// A result is registered when the back end pops the transaction that completes it,
// one line plus one pixel after its own sample.
// Synchronous reset; the line store is not cleared and needs no clearing pass.
// A four-entry queue decouples the sides; in_stall rises only when it is full.
module bayer_bilinear_demosaic_core import bbd_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_kind,
  input  logic [7:0]        in_pixel_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_red,
  output logic [7:0]        out_green,
  output logic [7:0]        out_blue,
  output logic [ROW_W-1:0]  out_row,
  output logic [COL_W-1:0]  out_col,
  output logic              out_last_of_frame,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  logic     push, q_full, pop, q_not_empty;
  q_entry_t push_entry, q_head;

  bbd_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_pixel_value (in_pixel_value),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .push           (push),
    .push_entry     (push_entry),
    .q_full         (q_full)
  );

  bbd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  bbd_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .not_empty         (q_not_empty),
    .head              (q_head),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_red           (out_red),
    .out_green         (out_green),
    .out_blue          (out_blue),
    .out_row           (out_row),
    .out_col           (out_col),
    .out_last_of_frame (out_last_of_frame)
  );

endmodule
